// ===== hdl/slb_pkg.sv =====
package slb_pkg;

    // bar geometry
    localparam int LED_COUNT   = 16;
    localparam int WARN_WIDTH  = 4;
    localparam int SHIFT_WIDTH = 2;
    localparam int MID         = LED_COUNT / 2;

    // field widths
    localparam int RPM_W      = 14;
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int IDX_W      = 6;
    localparam int RED_W      = 7;
    localparam int GREEN_W    = 4;

    // blackout math: numerator magnitude is (rpm - low) * MID
    localparam int NUM_W = RPM_W + $clog2(MID + 1);
    localparam int B_W   = NUM_W + 2;

    // frame queue between front and back
    localparam int FIFO_DEPTH = 2;

    // register reset values
    localparam logic [RPM_W-1:0]    RST_LOW_LIMIT    = RPM_W'(3000);
    localparam logic [RPM_W-1:0]    RST_SHIFT_POINT  = RPM_W'(6500);
    localparam logic [PERIOD_W-1:0] RST_FLASH_PERIOD = PERIOD_W'(100);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LIMIT    = 2'd0,
        CFG_SHIFT_POINT  = 2'd1,
        CFG_FLASH_PERIOD = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ZONE_OFF    = 2'd0,
        ZONE_NORMAL = 2'd1,
        ZONE_WARN   = 2'd2,
        ZONE_SHIFT  = 2'd3
    } t_zone;

    // colors per zone
    localparam logic [RED_W-1:0]   RED_NORMAL   = RED_W'(30);
    localparam logic [GREEN_W-1:0] GREEN_NORMAL = GREEN_W'(15);
    localparam logic [RED_W-1:0]   RED_WARN     = RED_W'(80);
    localparam logic [GREEN_W-1:0] GREEN_WARN   = GREEN_W'(10);
    localparam logic [RED_W-1:0]   RED_SHIFT    = RED_W'(80);
    localparam logic [GREEN_W-1:0] GREEN_SHIFT  = GREEN_W'(0);

    typedef struct packed {
        logic [RPM_W-1:0]    rpm_low_limit;
        logic [RPM_W-1:0]    rpm_shift_point;
        logic [PERIOD_W-1:0] flash_period_ms;
    } t_cfg;

    // one classified frame, handed from front to back
    typedef struct packed {
        logic                  dark;
        logic                  blank_shift;
        logic signed [B_W-1:0] blank_half;
    } t_frame;

endpackage

// ===== hdl/slb_in_if.sv =====
interface slb_in_if;
    import slb_pkg::*;

    logic             valid;
    logic             ready;
    logic [RPM_W-1:0] smoothed_rpm;
    logic [RPM_W-1:0] engine_rpm;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output smoothed_rpm, output engine_rpm, output now_ms,
                    input ready);
    modport sink   (input valid, input smoothed_rpm, input engine_rpm, input now_ms,
                    output ready);
endinterface

// ===== hdl/slb_out_if.sv =====
interface slb_out_if;
    import slb_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   led_index;
    logic [1:0]         zone;
    logic [RED_W-1:0]   red;
    logic [GREEN_W-1:0] green;
    logic               last;

    modport source (output valid, output led_index, output zone, output red, output green,
                    output last, input ready);
    modport sink   (input valid, input led_index, input zone, input red, input green,
                    input last, output ready);
endinterface

// ===== hdl/slb_div.sv =====
module slb_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [slb_pkg::NUM_W-1:0]   i_num,
    input  logic [slb_pkg::RPM_W-1:0]   i_den,
    output logic                        o_done,
    output logic [slb_pkg::NUM_W-1:0]   o_quot
);
    import slb_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [RPM_W-1:0] r_rem;
    logic [RPM_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [RPM_W:0]   s_trial;
    logic             s_fit;

    // restoring step: bring down the next dividend bit
    assign s_trial = {r_rem, r_quo[NUM_W-1]};
    assign s_fit   = s_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_rem  <= s_fit ? RPM_W'(s_trial - {1'b0, r_den}) : RPM_W'(s_trial);
                r_quo  <= {r_quo[NUM_W-2:0], s_fit};
                r_cnt  <= r_cnt - 1'b1;
                r_busy <= r_cnt != CNT_W'(1);
                r_done <= r_cnt == CNT_W'(1);
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ===== hdl/slb_fifo.sv =====
module slb_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  slb_pkg::t_frame i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output slb_pkg::t_frame o_head
);
    import slb_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_frame           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             s_push;
    logic             s_pop;

    assign o_full  = r_cnt == CNT_W'(FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= wrap_inc(r_wp);
            end
            if (s_pop) begin
                r_rp <= wrap_inc(r_rp);
            end
            case ({s_push, s_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ===== hdl/slb_front.sv =====
module slb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  slb_pkg::t_cfg   i_cfg,
    slb_in_if.sink          i_in,
    output logic            o_push,
    output slb_pkg::t_frame o_frame,
    input  logic            i_full
);
    import slb_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_state;

    t_state            r_state;
    t_frame            r_frame;
    logic              r_den_neg;
    logic              r_phase;
    logic [TIME_W-1:0] r_last_ms;

    logic                     s_accept;
    logic                     s_dark;
    logic [RPM_W-1:0]         s_diff;
    logic signed [RPM_W:0]    s_den;
    logic [RPM_W-1:0]         s_den_mag;
    logic [NUM_W-1:0]         s_num;
    logic                     s_flash;
    logic                     s_start;
    logic                     s_div_done;
    logic [NUM_W-1:0]         s_quot;
    logic signed [B_W-1:0]    s_q_signed;

    assign i_in.ready = r_state == F_IDLE;
    assign s_accept   = i_in.valid && i_in.ready;

    // classify the frame
    assign s_dark    = i_in.smoothed_rpm < i_cfg.rpm_low_limit;
    assign s_diff    = i_in.smoothed_rpm - i_cfg.rpm_low_limit;
    assign s_den     = $signed({1'b0, i_cfg.rpm_shift_point})
                       - $signed({1'b0, i_cfg.rpm_low_limit});
    assign s_den_mag = s_den[RPM_W] ? RPM_W'(-s_den) : RPM_W'(s_den);
    assign s_num     = NUM_W'(s_diff) * NUM_W'(MID);
    assign s_flash   = (i_in.engine_rpm > i_cfg.rpm_shift_point) &&
                       ((i_in.now_ms - r_last_ms) > TIME_W'(i_cfg.flash_period_ms));
    assign s_start   = s_accept && !s_dark && (s_den != '0);

    slb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_num   (s_num),
        .i_den   (s_den_mag),
        .o_done  (s_div_done),
        .o_quot  (s_quot)
    );

    // numerator is never positive: quotient is negative when divisor is positive
    assign s_q_signed = $signed({2'b00, s_quot});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_phase   <= 1'b0;
            r_last_ms <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (s_accept) begin
                        r_frame.dark        <= s_dark;
                        r_frame.blank_shift <= !s_dark && s_flash && !r_phase;
                        r_frame.blank_half  <= '0;
                        r_den_neg           <= s_den[RPM_W];
                        if (!s_dark && s_flash) begin
                            r_phase   <= !r_phase;
                            r_last_ms <= i_in.now_ms;
                        end
                        r_state <= s_start ? F_DIV : F_PUSH;
                    end
                end
                F_DIV: begin
                    if (s_div_done) begin
                        r_frame.blank_half <= (r_den_neg ? s_q_signed : -s_q_signed)
                                              + B_W'(MID);
                        r_state            <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_frame = r_frame;
endmodule

// ===== hdl/slb_back.sv =====
module slb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  slb_pkg::t_frame i_head,
    output logic            o_pop,
    slb_out_if.source       o_out
);
    import slb_pkg::*;

    t_frame             r_frame;
    logic               r_active;
    logic [IDX_W-1:0]   r_idx;
    logic               r_valid;
    logic [IDX_W-1:0]   r_led_index;
    t_zone              r_zone;
    logic [RED_W-1:0]   r_red;
    logic [GREEN_W-1:0] r_green;
    logic               r_last;

    logic                  s_load;
    logic                  s_last_led;
    logic signed [B_W:0]   s_d;
    logic signed [B_W:0]   s_b;
    logic                  s_blackout;
    t_zone                 s_zone;
    logic [RED_W-1:0]      s_red;
    logic [GREEN_W-1:0]    s_green;

    // zone painting by distance from the middle, later spans win
    function automatic t_zone base_zone(input logic [IDX_W-1:0] idx);
        int    i;
        t_zone z;
        i = int'(idx);
        z = ZONE_OFF;
        if ((i >= 0 && i <= MID - WARN_WIDTH) ||
            (i >= MID + WARN_WIDTH + 1 && i <= LED_COUNT - 1))
            z = ZONE_NORMAL;
        if ((i >= MID - WARN_WIDTH - 1 && i <= MID - SHIFT_WIDTH) ||
            (i >= MID + SHIFT_WIDTH + 1 && i <= MID + WARN_WIDTH))
            z = ZONE_WARN;
        if (i >= MID - SHIFT_WIDTH - 1 && i <= MID + SHIFT_WIDTH)
            z = ZONE_SHIFT;
        return z;
    endfunction

    function automatic logic in_shift_span(input logic [IDX_W-1:0] idx);
        int i;
        i = int'(idx);
        return (i >= MID - SHIFT_WIDTH - 1) && (i <= MID + SHIFT_WIDTH);
    endfunction

    assign o_pop      = !r_active && !i_empty;
    assign s_load     = r_active && (!r_valid || o_out.ready);
    assign s_last_led = r_idx == IDX_W'(LED_COUNT - 1);

    // blackout span mid-b .. mid+b-1, in offsets from the middle
    assign s_d        = $signed({{(B_W + 1 - IDX_W){1'b0}}, r_idx}) - (B_W + 1)'(MID);
    assign s_b        = (B_W + 1)'(r_frame.blank_half);
    assign s_blackout = (s_d + s_b >= 0) && (s_d < s_b);

    always_comb begin
        s_zone = base_zone(r_idx);
        if (s_blackout)
            s_zone = ZONE_OFF;
        if (r_frame.blank_shift && in_shift_span(r_idx))
            s_zone = ZONE_OFF;
        if (r_frame.dark)
            s_zone = ZONE_OFF;
    end

    always_comb begin
        case (s_zone)
            ZONE_NORMAL: begin s_red = RED_NORMAL; s_green = GREEN_NORMAL; end
            ZONE_WARN:   begin s_red = RED_WARN;   s_green = GREEN_WARN;   end
            ZONE_SHIFT:  begin s_red = RED_SHIFT;  s_green = GREEN_SHIFT;  end
            default:     begin s_red = '0;         s_green = '0;           end
        endcase
    end

    // frame walker and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (o_pop) begin
                r_frame  <= i_head;
                r_active <= 1'b1;
                r_idx    <= '0;
            end
            if (s_load) begin
                r_valid     <= 1'b1;
                r_led_index <= r_idx;
                r_zone      <= s_zone;
                r_red       <= s_red;
                r_green     <= s_green;
                r_last      <= s_last_led;
                r_idx       <= r_idx + 1'b1;
                if (s_last_led)
                    r_active <= 1'b0;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.led_index = r_led_index;
    assign o_out.zone      = r_zone;
    assign o_out.red       = r_red;
    assign o_out.green     = r_green;
    assign o_out.last      = r_last;
endmodule

// ===== hdl/shift_light_led_bar.sv =====
// Shift light LED bar.
// i_in carries one display frame per word: smoothed rpm, raw engine rpm and a
// millisecond timestamp. o_out returns LED_COUNT words per frame, one per LED in
// index order, with zone, red and green; last marks the final LED.
// The config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the low limit, the
// shift point and the flash period; write it only while the bar is idle.
// Path: a frame whose blackout needs the divide passes the bit-serial divider,
// the front's frame register, the queue, the back's frame register and the output
// register; dark frames and equal limits skip the divide. LEDs then stream one
// per cycle while o_out.ready stays high. The front takes a new frame only once
// the last one has entered the queue.
// A two-entry frame queue lets the front classify the next frame while LEDs of
// the previous one still drain.
// Reset (synchronous, active low) restores default limits, clears flash phase
// and flash timer, and empties the queue and output register.
// When the receiver stalls the output word holds; the queue fills and then
// i_in.ready drops until room frees up.
module shift_light_led_bar (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    slb_in_if.sink                          i_in,
    slb_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [slb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [slb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import slb_pkg::*;

    t_cfg   r_cfg;
    logic   s_push;
    t_frame s_frame;
    logic   s_full;
    logic   s_empty;
    logic   s_pop;
    t_frame s_head;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rpm_low_limit   <= RST_LOW_LIMIT;
            r_cfg.rpm_shift_point <= RST_SHIFT_POINT;
            r_cfg.flash_period_ms <= RST_FLASH_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOW_LIMIT:    r_cfg.rpm_low_limit   <= i_cfg_data[RPM_W-1:0];
                CFG_SHIFT_POINT:  r_cfg.rpm_shift_point <= i_cfg_data[RPM_W-1:0];
                CFG_FLASH_PERIOD: r_cfg.flash_period_ms <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    slb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_push  (s_push),
        .o_frame (s_frame),
        .i_full  (s_full)
    );

    slb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_frame),
        .i_pop   (s_pop),
        .o_full  (s_full),
        .o_empty (s_empty),
        .o_head  (s_head)
    );

    slb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (s_empty),
        .i_head  (s_head),
        .o_pop   (s_pop),
        .o_out   (o_out)
    );
endmodule

// ===== tb/tb_shift_light_led_bar.sv =====
`timescale 1ns / 1ps

module tb_shift_light_led_bar;
    import slb_pkg::*;

    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 48;
    localparam int     MAX_REPORTS  = 100;
    localparam int     FRAMES_PER_PHASE = 40;
    localparam int     RPM_MAX      = (1 << RPM_W) - 1;
    localparam longint LIMIT_NS     = 1_000_000;

    // index 3 decodes to no register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // one LED word as it leaves the bar
    typedef struct packed {
        logic [IDX_W-1:0]   led_index;
        t_zone              zone;
        logic [RED_W-1:0]   red;
        logic [GREEN_W-1:0] green;
        logic               last;
    } t_led_word;

    // Bar predictor with its own copy of the limits and the flash state
    class led_bar_scoreboard;
        logic [RPM_W-1:0]    low_limit;
        logic [RPM_W-1:0]    shift_point;
        logic [PERIOD_W-1:0] flash_period;
        logic                flash_on;
        logic [TIME_W-1:0]   last_toggle;
        t_led_word           leds_due[$];
        int                  errors;
        int                  frames;
        int                  words;
        int                  toggles;
        int                  dark_frames;

        function new();
            low_limit    = RST_LOW_LIMIT;
            shift_point  = RST_SHIFT_POINT;
            flash_period = RST_FLASH_PERIOD;
            flash_on     = 1'b0;
            last_toggle  = '0;
            errors       = 0;
            frames       = 0;
            words        = 0;
            toggles      = 0;
            dark_frames  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LOW_LIMIT:    low_limit    = data[RPM_W-1:0];
                CFG_SHIFT_POINT:  shift_point  = data[RPM_W-1:0];
                CFG_FLASH_PERIOD: flash_period = data[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        // classify one frame and queue its LED words
        function void note_frame(logic [RPM_W-1:0] rpm, logic [RPM_W-1:0] raw,
                                 logic [TIME_W-1:0] now);
            int                rpm_i;
            int                low_i;
            int                shift_i;
            int                span;
            int                half;
            logic              dark;
            logic              blank;
            logic [TIME_W-1:0] elapsed;
            t_zone             z;
            t_led_word         w;

            rpm_i   = int'(rpm);
            low_i   = int'(low_limit);
            shift_i = int'(shift_point);
            span    = shift_i - low_i;
            dark    = rpm_i < low_i;
            blank   = 1'b0;
            half    = 0;
            frames++;

            if (dark) begin
                dark_frames++;
            end else begin
                // signed, truncating toward zero, no clamp
                if (span != 0)
                    half = ((rpm_i - low_i) * (-MID)) / span + MID;
                elapsed = now - last_toggle;
                if (raw > shift_point && elapsed > flash_period) begin
                    blank       = !flash_on;
                    last_toggle = now;
                    flash_on    = !flash_on;
                    toggles++;
                end
            end

            for (int i = 0; i < LED_COUNT; i++) begin
                z = ZONE_OFF;
                if (!dark) begin
                    // later paint wins
                    if ((i <= MID - WARN_WIDTH) || (i >= MID + WARN_WIDTH + 1))
                        z = ZONE_NORMAL;
                    if ((i >= MID - WARN_WIDTH - 1 && i <= MID - SHIFT_WIDTH) ||
                        (i >= MID + SHIFT_WIDTH + 1 && i <= MID + WARN_WIDTH))
                        z = ZONE_WARN;
                    if (i >= MID - SHIFT_WIDTH - 1 && i <= MID + SHIFT_WIDTH)
                        z = ZONE_SHIFT;
                    // centre blackout
                    if (i >= MID - half && i <= MID + half - 1)
                        z = ZONE_OFF;
                    // flash blanks the shift span on the off-going toggle
                    if (blank && i >= MID - SHIFT_WIDTH - 1 && i <= MID + SHIFT_WIDTH)
                        z = ZONE_OFF;
                end
                w.led_index = IDX_W'(i);
                w.zone      = z;
                case (z)
                    ZONE_NORMAL: begin
                        w.red   = RED_NORMAL;
                        w.green = GREEN_NORMAL;
                    end
                    ZONE_WARN: begin
                        w.red   = RED_WARN;
                        w.green = GREEN_WARN;
                    end
                    ZONE_SHIFT: begin
                        w.red   = RED_SHIFT;
                        w.green = GREEN_SHIFT;
                    end
                    default: begin
                        w.red   = '0;
                        w.green = '0;
                    end
                endcase
                w.last = (i == LED_COUNT - 1);
                leds_due.push_back(w);
            end
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
            else if (errors == MAX_REPORTS + 1)
                $display("further mismatches counted but not shown");
        endfunction

        // compare one LED word against the oldest one due
        function void check_led(t_led_word got);
            t_led_word want;

            if (leds_due.size() == 0) begin
                flag("led_index (no frame pending)", 32'hFFFF_FFFF, 32'(got.led_index));
                return;
            end
            want = leds_due.pop_front();
            words++;
            if (got.led_index !== want.led_index)
                flag("led_index", 32'(want.led_index), 32'(got.led_index));
            if (got.zone !== want.zone)
                flag("zone", 32'(want.zone), 32'(got.zone));
            if (got.red !== want.red)
                flag("red", 32'(want.red), 32'(got.red));
            if (got.green !== want.green)
                flag("green", 32'(want.green), 32'(got.green));
            if (got.last !== want.last)
                flag("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic                  hold_req;
    int                    hold_left = 0;
    int                    send_idle;
    int                    recv_stall;
    logic [TIME_W-1:0]     clock_ms;
    t_led_word             seen_word;

    led_bar_scoreboard     sb = new();

    slb_in_if  in_if ();
    slb_out_if out_if ();

    shift_light_led_bar dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // LED receiver: check accepted words, then decide next ready
    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready) begin
            seen_word = '{out_if.led_index, t_zone'(out_if.zone), out_if.red,
                          out_if.green, out_if.last};
            sb.check_led(seen_word);
        end
        if (hold_req)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // offer one frame after a random idle gap; valid stays up for the next word
    task automatic send_frame(input logic [RPM_W-1:0] rpm, input logic [RPM_W-1:0] raw,
                              input logic [TIME_W-1:0] now);
        int gap;

        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.smoothed_rpm <= rpm;
        in_if.engine_rpm   <= raw;
        in_if.now_ms       <= now;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_frame(rpm, raw, now);
    endtask

    // caller lowers the write enable after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // stop offering, let every due LED arrive, then let the pipe settle
    task automatic drain_bar();
        in_if.valid <= 1'b0;
        while (sb.leds_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int                pick;
        logic [RPM_W-1:0]  rpm;
        logic [RPM_W-1:0]  raw;
        logic [RPM_W-1:0]  bar_lo;
        logic [RPM_W-1:0]  bar_hi;
        logic [RPM_W-1:0]  lo_pick;

        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.smoothed_rpm = '0;
        in_if.engine_rpm   = '0;
        in_if.now_ms       = '0;
        out_if.ready       = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_LOW_LIMIT;
        i_cfg_data         = '0;
        hold_req           = 1'b0;
        send_idle          = 0;
        recv_stall         = 0;
        clock_ms           = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at reset limits (3000 / 6500 / 100 ms)
        send_frame(0, 0, 0);                             // dark
        send_frame(2999, 16383, 1000);                   // dark, flash state untouched
        send_frame(3000, 0, 1000);                       // whole bar blacked out
        send_frame(4750, 0, 1010);                       // half blackout
        send_frame(4000, 0, 1015);                       // truncating divide
        send_frame(6500, 6500, 1020);                    // full bar, raw not above shift
        send_frame(16383, 16383, 1030);                  // flash on, shift blanked
        send_frame(16383, 16383, 1100);                  // period not elapsed
        send_frame(16383, 16383, 1130);                  // exactly the period: no toggle
        send_frame(16383, 16383, 1131);                  // toggle back, no blank
        send_frame(8000, 8000, 1300);                    // toggle, blank
        send_frame(5000, 9000, 32'hFFFF_FFF0);
        send_frame(5000, 9000, 32'h0000_0080);           // timer wraps
        send_frame(16383, 16383, 32'hFFFF_FFFF);
        send_frame(14'h1555, 14'h2AAA, 32'h5555_5555);
        send_frame(14'h2AAA, 14'h1555, 32'hAAAA_AAAA);
        clock_ms = 32'hAAAA_AAAA;
        drain_bar();

        for (int p = 0; p < 5; p++) begin
            // new limits while the bar is idle
            case (p)
                1: begin
                    // full range, upper data bits must be masked off
                    write_reg(CFG_LOW_LIMIT, 16'hC000);
                    write_reg(CFG_SHIFT_POINT, 16'hFFFF);
                    write_reg(CFG_FLASH_PERIOD, 16'h0000);
                    write_reg(CFG_UNUSED, 16'hFFFF);
                end
                2: begin
                    // shift point below low limit
                    write_reg(CFG_LOW_LIMIT, 16'h3FFF);
                    write_reg(CFG_SHIFT_POINT, 16'h4001);
                    write_reg(CFG_FLASH_PERIOD, 16'hFFFF);
                end
                3: begin
                    // equal limits
                    write_reg(CFG_LOW_LIMIT, 16'd5000);
                    write_reg(CFG_SHIFT_POINT, 16'd5000);
                    write_reg(CFG_FLASH_PERIOD, 16'd50);
                end
                4: begin
                    lo_pick = RPM_W'($urandom_range(12000, 0));
                    write_reg(CFG_LOW_LIMIT, CFG_DATA_W'(lo_pick));
                    write_reg(CFG_SHIFT_POINT, CFG_DATA_W'($urandom_range(RPM_MAX, lo_pick + 1)));
                    write_reg(CFG_FLASH_PERIOD, CFG_DATA_W'($urandom_range(300, 0)));
                end
                default: ;
            endcase
            i_cfg_we <= 1'b0;

            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 73; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 73; end
                default: begin send_idle = 19; recv_stall = 19; end
            endcase

            // long receiver hold-off so the frame queue fills and input stalls
            if (p == 0) begin
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end

            bar_lo = (sb.low_limit < sb.shift_point) ? sb.low_limit : sb.shift_point;
            bar_hi = (sb.low_limit < sb.shift_point) ? sb.shift_point : sb.low_limit;
            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 60)
                    rpm = RPM_W'($urandom_range(bar_hi, bar_lo));
                else if (pick < 80)
                    rpm = RPM_W'($urandom_range(RPM_MAX, 0));
                else begin
                    case ($urandom_range(3))
                        0: rpm = bar_lo - 1'b1;
                        1: rpm = bar_lo;
                        2: rpm = bar_hi;
                        default: rpm = bar_hi + 1'b1;
                    endcase
                end
                if ($urandom_range(1))
                    raw = RPM_W'($urandom_range(RPM_MAX, sb.shift_point));
                else
                    raw = RPM_W'($urandom_range(RPM_MAX, 0));
                if ($urandom_range(99) < 85)
                    clock_ms = clock_ms + $urandom_range(2 * sb.flash_period + 2, 0);
                else
                    clock_ms = $urandom();
                send_frame(rpm, raw, clock_ms);
            end
            drain_bar();
        end

        $display("Checked %0d frames, %0d LED words; %0d flash toggles, %0d dark frames.",
                 sb.frames, sb.words, sb.toggles, sb.dark_frames);
        $display("Limits: reset, full span, inverted, equal, random; unused index written.");
        if (sb.errors == 0 && sb.leds_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hang guard
    initial begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/slb_pkg.sv
hdl/slb_in_if.sv
hdl/slb_out_if.sv
hdl/slb_div.sv
hdl/slb_fifo.sv
hdl/slb_front.sv
hdl/slb_back.sv
hdl/shift_light_led_bar.sv
tb/tb_shift_light_led_bar.sv
